// ===== rtl/windowed_speed_record_tracker_assert.svh =====
// Assertion macros for the windowed speed record tracker.
`ifndef WINDOWED_SPEED_RECORD_TRACKER_ASSERT_SVH
`define WINDOWED_SPEED_RECORD_TRACKER_ASSERT_SVH

// same-cycle implication
`define WSRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wsrt_pkg.sv =====
// Shared types and constants for the windowed speed record tracker.
package wsrt_pkg;

	localparam int RING_DEPTH_DEF    = 2048;
	localparam int TABLE_ENTRIES_DEF = 10;

	localparam int WIN_W   = 12;
	localparam int RATE_W  = 5;
	localparam int SPAN_W  = 17;
	localparam int SPEED_W = 16;
	localparam int AVG_W   = 24;
	localparam int RUN_W   = 16;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int RANK_W  = 4;
	localparam int IDX_W   = 32;
	localparam int ACC_W   = 24;
	localparam int SUM_W   = 32;
	localparam int DIV_NW  = 40;
	localparam int DIV_DW  = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [WIN_W-1:0]  WINDOW_RESET = 12'd10;
	localparam logic [RATE_W-1:0] RATE_RESET   = 5'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;

	typedef struct packed {
		logic [SPEED_W-1:0] ground_speed;
		logic [RUN_W-1:0]   run_number;
		logic [HOUR_W-1:0]  clock_hour;
		logic [MIN_W-1:0]   clock_minute;
		logic [SEC_W-1:0]   clock_second;
	} item_t;

	typedef struct packed {
		logic [AVG_W-1:0]  window_average;
		logic [AVG_W-1:0]  run_maximum;
		logic [AVG_W-1:0]  display_maximum;
		logic [RANK_W-1:0] entry_rank;
		logic [AVG_W-1:0]  entry_speed;
		logic [HOUR_W-1:0] entry_hour;
		logic [MIN_W-1:0]  entry_minute;
		logic [SEC_W-1:0]  entry_second;
		logic [RUN_W-1:0]  entry_run;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [AVG_W-1:0]  speed;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
		logic [RUN_W-1:0]  run;
	} rec_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/wsrt_fifo.sv =====
// Small word queue used on the input and result sides.
module wsrt_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule

// ===== rtl/wsrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wsrt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wsrt_pkg::div_req_t req,
	output wsrt_pkg::div_rsp_t rsp
);
	localparam int NW    = wsrt_pkg::DIV_NW;
	localparam int DW    = wsrt_pkg::DIV_DW;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q, div_q;
	logic [DW:0]      trial;
	logic [DW+1:0]    diff;
	logic             ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign ge    = !diff[DW+1];

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;
endmodule

// ===== rtl/wsrt_core.sv =====
// Back end: rings, window sum, run maximum and ranked table sequencer.
module wsrt_core #(
	parameter int RING_DEPTH    = wsrt_pkg::RING_DEPTH_DEF,
	parameter int TABLE_ENTRIES = wsrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wsrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsrt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_empty,
	input  wsrt_pkg::item_t                    in_data,
	output logic                               in_pop,
	input  logic                               out_full,
	output logic                               out_push,
	output wsrt_pkg::result_t                  out_data,
	output wsrt_pkg::div_req_t                 div_req,
	input  wsrt_pkg::div_rsp_t                 div_rsp
);
	localparam int AW  = $clog2(RING_DEPTH);
	localparam int TIW = $clog2(TABLE_ENTRIES);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MODR  = 8'b0000_0010,
		ST_QDIV  = 8'b0000_0100,
		ST_ADD   = 8'b0000_1000,
		ST_RDW   = 8'b0001_0000,
		ST_ADIV  = 8'b0010_0000,
		ST_TRACK = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [wsrt_pkg::WIN_W-1:0]      win_q, w;
	logic [wsrt_pkg::RATE_W-1:0]     rate_q, r;
	logic [wsrt_pkg::SPAN_W-1:0]     span;
	logic                            sample_mode;
	wsrt_pkg::item_t                 item_q;
	logic [wsrt_pkg::IDX_W-1:0]      sidx_q, secidx_q, sidx_n, secidx_n;
	logic [wsrt_pkg::ACC_W-1:0]      acc_q;
	logic [wsrt_pkg::ACC_W:0]        acc_sum;
	logic [wsrt_pkg::SUM_W-1:0]      sum_q, sum_sub;
	logic [wsrt_pkg::SUM_W:0]        sum_add;
	logic [wsrt_pkg::SPEED_W-1:0]    addval_q, subval, qsat;
	logic                            sub_en_q, zero_seen_q, sorted_q;
	logic [wsrt_pkg::AVG_W-1:0]      avg_q, runmax_q, disp;
	logic [wsrt_pkg::RUN_W-1:0]      prev_q;
	wsrt_pkg::rec_t                  tbl_q [TABLE_ENTRIES];
	wsrt_pkg::rec_t                  tbl_n [TABLE_ENTRIES];
	wsrt_pkg::rec_t                  cand, entry;
	logic                            newmax, change;
	logic [TIW-1:0]                  pos, emit_cnt_q;
	logic                            emit_last;

	logic [wsrt_pkg::SPEED_W-1:0]    samp_mem [RING_DEPTH];
	logic [wsrt_pkg::SPEED_W-1:0]    sec_mem  [RING_DEPTH];
	logic [wsrt_pkg::SPEED_W-1:0]    samp_rd_q, sec_rd_q;
	logic [wsrt_pkg::IDX_W-1:0]      samp_rpos, sec_rpos;
	logic                            samp_we, sec_we;

	assign cfg_ready = 1'b1;
	assign r = (rate_q == '0) ? wsrt_pkg::RATE_W'(1) : rate_q;
	assign w = (win_q == '0) ? wsrt_pkg::WIN_W'(1) : win_q;
	assign span = wsrt_pkg::SPAN_W'(w) * wsrt_pkg::SPAN_W'(r);
	assign sample_mode = span < wsrt_pkg::SPAN_W'(RING_DEPTH);

	assign sidx_n   = sidx_q + wsrt_pkg::IDX_W'(1);
	assign secidx_n = secidx_q + wsrt_pkg::IDX_W'(1);
	assign acc_sum  = {1'b0, acc_q} + (wsrt_pkg::ACC_W + 1)'(in_data.ground_speed);
	assign qsat = (|div_rsp.quot[wsrt_pkg::DIV_NW-1:wsrt_pkg::SPEED_W]) ? '1 :
		div_rsp.quot[wsrt_pkg::SPEED_W-1:0];

	assign samp_rpos = sidx_q - wsrt_pkg::IDX_W'(span);
	assign sec_rpos  = secidx_q - wsrt_pkg::IDX_W'(w);
	assign samp_we   = (state_q == ST_IDLE) && !in_empty;
	assign sec_we    = (state_q == ST_QDIV) && div_rsp.done;

	// entry zero of the sample ring reads as zero until first written
	assign subval = !sample_mode ? sec_rd_q :
		((samp_rpos[AW-1:0] == '0) && !zero_seen_q) ? '0 : samp_rd_q;
	assign sum_add = {1'b0, sum_q} + (wsrt_pkg::SUM_W + 1)'(addval_q);
	assign sum_sub = !sub_en_q ? sum_q :
		(sum_q < wsrt_pkg::SUM_W'(subval)) ? '0 : sum_q - wsrt_pkg::SUM_W'(subval);

	always_ff @(posedge clk) begin
		if (samp_we)
			samp_mem[sidx_n[AW-1:0]] <= in_data.ground_speed;
		samp_rd_q <= samp_mem[samp_rpos[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sec_we)
			sec_mem[secidx_n[AW-1:0]] <= qsat;
		sec_rd_q <= sec_mem[sec_rpos[AW-1:0]];
	end

	// max update, run-change test and insertion of the finished run record
	always_comb begin
		newmax = runmax_q < avg_q;
		cand   = tbl_q[0];
		if (newmax) begin
			cand.speed  = avg_q;
			cand.hour   = item_q.clock_hour;
			cand.minute = item_q.clock_minute;
			cand.second = item_q.clock_second;
			cand.run    = item_q.run_number;
		end
		change = (item_q.run_number != prev_q) && (cand.run == prev_q);
		pos = '0;
		for (int j = 1; j < TABLE_ENTRIES; j++)
			pos = pos + TIW'(tbl_q[j].speed < cand.speed);
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (k < TABLE_ENTRIES - 1 && TIW'(k) < pos)
				tbl_n[k] = tbl_q[(k + 1) % TABLE_ENTRIES];
			else if (TIW'(k) == pos)
				tbl_n[k] = cand;
			else
				tbl_n[k] = tbl_q[k];
		end
		tbl_n[0] = '0;
	end

	always_comb begin
		disp = (runmax_q > tbl_q[TABLE_ENTRIES-1].speed) ? runmax_q :
			tbl_q[TABLE_ENTRIES-1].speed;
		entry = (emit_cnt_q == '0) ? '0 : tbl_q[emit_cnt_q];
		emit_last = !sorted_q || (emit_cnt_q == TIW'(TABLE_ENTRIES - 1));
		out_data.window_average  = avg_q;
		out_data.run_maximum     = runmax_q;
		out_data.display_maximum = disp;
		out_data.entry_rank      = wsrt_pkg::RANK_W'(emit_cnt_q);
		out_data.entry_speed     = entry.speed;
		out_data.entry_hour      = entry.hour;
		out_data.entry_minute    = entry.minute;
		out_data.entry_second    = entry.second;
		out_data.entry_run       = entry.run;
		out_data.last            = emit_last;
	end

	assign in_pop   = samp_we;
	assign out_push = (state_q == ST_EMIT) && !out_full;

	always_comb begin
		div_req = '0;
		unique case (state_q) inside
			ST_IDLE: begin
				div_req.start    = !in_empty;
				div_req.dividend = wsrt_pkg::DIV_NW'(sidx_n);
				div_req.divisor  = wsrt_pkg::DIV_DW'(r);
			end
			ST_MODR: begin
				div_req.start    = div_rsp.done && (div_rsp.rem == '0);
				div_req.dividend = wsrt_pkg::DIV_NW'(acc_q);
				div_req.divisor  = wsrt_pkg::DIV_DW'(r);
			end
			ST_RDW: begin
				div_req.start    = 1'b1;
				div_req.dividend = {sum_sub, 8'h00};
				div_req.divisor  = sample_mode ? span : wsrt_pkg::DIV_DW'(w);
			end
			ST_QDIV, ST_ADD, ST_ADIV, ST_TRACK, ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= wsrt_pkg::WINDOW_RESET;
			rate_q      <= wsrt_pkg::RATE_RESET;
			sidx_q      <= '0;
			secidx_q    <= '1;
			acc_q       <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			runmax_q    <= '0;
			prev_q      <= '0;
			zero_seen_q <= 1'b0;
			sorted_q    <= 1'b0;
			sub_en_q    <= 1'b0;
			emit_cnt_q  <= '0;
			addval_q    <= '0;
			item_q      <= '0;
			for (int k = 0; k < TABLE_ENTRIES; k++)
				tbl_q[k] <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == wsrt_pkg::CFG_WINDOW)
					win_q <= cfg_data[wsrt_pkg::WIN_W-1:0];
				else if (cfg_index == wsrt_pkg::CFG_RATE)
					rate_q <= cfg_data[wsrt_pkg::RATE_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!in_empty) begin
						item_q     <= in_data;
						sidx_q     <= sidx_n;
						acc_q      <= acc_sum[wsrt_pkg::ACC_W] ? '1 :
							acc_sum[wsrt_pkg::ACC_W-1:0];
						sorted_q   <= 1'b0;
						emit_cnt_q <= '0;
						if (sidx_n[AW-1:0] == '0)
							zero_seen_q <= 1'b1;
						state_q    <= ST_MODR;
					end
				end
				ST_MODR: begin
					if (div_rsp.done) begin
						if (div_rsp.rem == '0)
							state_q <= ST_QDIV;
						else if (sample_mode) begin
							addval_q <= item_q.ground_speed;
							state_q  <= ST_ADD;
						end else
							state_q <= ST_EMIT;
					end
				end
				ST_QDIV: begin
					if (div_rsp.done) begin
						secidx_q <= secidx_n;
						acc_q    <= '0;
						addval_q <= sample_mode ? item_q.ground_speed : qsat;
						state_q  <= ST_ADD;
					end
				end
				ST_ADD: begin
					sum_q    <= sum_add[wsrt_pkg::SUM_W] ? '1 : sum_add[wsrt_pkg::SUM_W-1:0];
					sub_en_q <= sample_mode ? (sidx_q >= wsrt_pkg::IDX_W'(span)) :
						(secidx_q >= wsrt_pkg::IDX_W'(w));
					state_q  <= ST_RDW;
				end
				ST_RDW: begin
					sum_q   <= sum_sub;
					state_q <= ST_ADIV;
				end
				ST_ADIV: begin
					if (div_rsp.done) begin
						avg_q   <= (|div_rsp.quot[wsrt_pkg::DIV_NW-1:wsrt_pkg::AVG_W]) ? '1 :
							div_rsp.quot[wsrt_pkg::AVG_W-1:0];
						state_q <= ST_TRACK;
					end
				end
				ST_TRACK: begin
					if (change) begin
						for (int k = 0; k < TABLE_ENTRIES; k++)
							tbl_q[k] <= tbl_n[k];
						runmax_q <= '0;
						sorted_q <= 1'b1;
					end else begin
						tbl_q[0] <= cand;
						if (newmax)
							runmax_q <= avg_q;
					end
					prev_q  <= item_q.run_number;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_full) begin
						if (emit_last)
							state_q <= ST_IDLE;
						else
							emit_cnt_q <= emit_cnt_q + TIW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/windowed_speed_record_tracker.sv =====
// Top level of the windowed speed record tracker.
// Samples enter through a two-word input queue and results leave through a four-word
// result queue, so both sides can stall independently of the back end. The back end
// handles one sample at a time and runs every division on one shared bit-serial
// divider: the rate phase of the sample count, the per-second mean when a second closes,
// and the window average. A sample in second mode between second boundaries needs only
// the rate-phase division, in sample mode also the window average, and on a second
// boundary all three. Each sample yields one result word, and TABLE_ENTRIES - 1 more
// after a run change; a stalled result side holds the back end.
// RING_DEPTH must be a power of two. The rings need no clearing pass: ring entry zero
// of the sample ring reads as zero until first written, and every other entry that is
// read has been written before.
module windowed_speed_record_tracker #(
	parameter int RING_DEPTH    = wsrt_pkg::RING_DEPTH_DEF,
	parameter int TABLE_ENTRIES = wsrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  wsrt_pkg::item_t                 item,
	output logic                            empty,
	input  logic                            pop,
	output wsrt_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wsrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsrt_pkg::CFG_DATA_W-1:0] cfg_data
);
	`include "windowed_speed_record_tracker_assert.svh"

	wsrt_pkg::item_t    in_data;
	logic               in_empty, in_pop;
	wsrt_pkg::result_t  out_data;
	logic               out_full, out_push;
	wsrt_pkg::div_req_t div_req;
	wsrt_pkg::div_rsp_t div_rsp;

	wsrt_fifo #(.T(wsrt_pkg::item_t), .DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(item), .full(full),
		.pop(in_pop), .rdata(in_data), .empty(in_empty)
	);

	wsrt_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	wsrt_core #(.RING_DEPTH(RING_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES)) u_core (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_empty(in_empty), .in_data(in_data), .in_pop(in_pop),
		.out_full(out_full), .out_push(out_push), .out_data(out_data),
		.div_req(div_req), .div_rsp(div_rsp)
	);

	wsrt_fifo #(.T(wsrt_pkg::result_t), .DEPTH(4)) u_back (
		.clk(clk), .arst_n(arst_n),
		.push(out_push), .wdata(out_data), .full(out_full),
		.pop(pop), .rdata(result), .empty(empty)
	);

	`WSRT_ASSERT_NOW(a_status_blank, !empty && result.entry_rank == '0,
		result.entry_speed == '0 && result.entry_run == '0, "status word carries an entry")
	`WSRT_ASSERT_NOW(a_disp_ge_max, !empty,
		result.display_maximum >= result.run_maximum, "display maximum below run maximum")
	`WSRT_ASSERT_NOW(a_last_rank, !empty && result.last && result.entry_rank != '0,
		result.entry_rank == wsrt_pkg::RANK_W'(TABLE_ENTRIES - 1), "table dump ends early")
	`WSRT_ASSERT_NEXT(a_rank_seq, pop && !empty && !result.last,
		empty || result.entry_rank == $past(result.entry_rank) + 4'd1, "rank out of order")
endmodule

// ===== verif/windowed_speed_record_tracker_tb.sv =====
// Testbench for the windowed speed record tracker: random and directed samples, scoreboard.
module windowed_speed_record_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING    = wsrt_pkg::RING_DEPTH_DEF;
	localparam int RAW     = $clog2(RING);
	localparam int ENTRIES = wsrt_pkg::TABLE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 800000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	wsrt_pkg::item_t item;
	logic empty;
	logic pop;
	wsrt_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [wsrt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wsrt_pkg::CFG_DATA_W-1:0] cfg_data;

	windowed_speed_record_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// tracker model state
	logic [wsrt_pkg::WIN_W-1:0]  win_secs;
	logic [wsrt_pkg::RATE_W-1:0] rate;
	logic [15:0] speed_ring [RING];
	logic [15:0] mean_ring [RING];
	logic [31:0] speed_idx;
	logic [31:0] mean_idx;
	logic [31:0] sec_acc;
	logic [31:0] win_sum;
	logic [23:0] run_max;
	logic [15:0] prev_run;
	logic [23:0] avg;
	wsrt_pkg::rec_t records [ENTRIES];

	wsrt_pkg::result_t expected_words [$];
	int errors;
	int cycles;
	bit idling;
	logic [4:0] hh;
	logic [5:0] mm;
	logic [5:0] ss;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("windowed_speed_record_tracker_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		pop <= arst_n && (!idling || $urandom_range(99) >= 30);

	function automatic logic [23:0] scaled(logic [31:0] div);
		logic [39:0] q;
		q = {win_sum, 8'd0} / {8'd0, div};
		return (q > 40'hFFFFFF) ? 24'hFFFFFF : q[23:0];
	endfunction

	function automatic void sum_add(logic [15:0] v);
		logic [32:0] t;
		t = {1'b0, win_sum} + {17'd0, v};
		win_sum = t[32] ? 32'hFFFFFFFF : t[31:0];
	endfunction

	function automatic void sum_sub(logic [15:0] v);
		win_sum = (win_sum < {16'd0, v}) ? 32'd0 : win_sum - {16'd0, v};
	endfunction

	function automatic bit track_run(wsrt_pkg::item_t it);
		wsrt_pkg::rec_t t;
		if (run_max < avg) begin
			run_max = avg;
			records[0] = '{avg, it.clock_hour, it.clock_minute, it.clock_second, it.run_number};
		end
		if (it.run_number != prev_run && records[0].run == prev_run) begin
			for (int i = 0; i < ENTRIES - 1; i++)
				for (int j = 0; j < ENTRIES - 1 - i; j++)
					if (records[j].speed > records[j+1].speed) begin
						t = records[j];
						records[j] = records[j+1];
						records[j+1] = t;
					end
			records[0] = '0;
			run_max = 0;
			prev_run = it.run_number;
			return 1;
		end
		prev_run = it.run_number;
		return 0;
	endfunction

	function automatic void predict_words(wsrt_pkg::item_t it);
		logic [31:0] r, w, span, q, sm1;
		bit closes, sorted;
		logic [23:0] disp;
		wsrt_pkg::result_t wd;
		r = (rate != '0) ? 32'(rate) : 32'd1;
		w = (win_secs != '0) ? 32'(win_secs) : 32'd1;
		span = w * r;
		sorted = 0;
		speed_idx++;
		speed_ring[speed_idx[RAW-1:0]] = it.ground_speed;
		sec_acc = sec_acc + 32'(it.ground_speed);
		if (sec_acc > 32'hFFFFFF)
			sec_acc = 32'hFFFFFF;
		closes = (speed_idx % r) == 0;
		if (closes) begin
			q = sec_acc / r;
			mean_idx++;
			mean_ring[mean_idx[RAW-1:0]] = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
			sec_acc = 0;
		end
		if (span < 32'(RING)) begin
			sum_add(speed_ring[speed_idx[RAW-1:0]]);
			if (speed_idx >= span) begin
				sm1 = speed_idx - span;
				sum_sub(speed_ring[sm1[RAW-1:0]]);
			end
			avg = scaled(span);
			sorted = track_run(it);
		end else if (closes) begin
			sum_add(mean_ring[mean_idx[RAW-1:0]]);
			if (mean_idx >= w) begin
				sm1 = mean_idx - w;
				sum_sub(mean_ring[sm1[RAW-1:0]]);
			end
			avg = scaled(w);
			sorted = track_run(it);
		end
		disp = (run_max > records[ENTRIES-1].speed) ? run_max : records[ENTRIES-1].speed;
		wd = '0;
		wd.window_average = avg;
		wd.run_maximum = run_max;
		wd.display_maximum = disp;
		wd.last = !sorted;
		expected_words.push_back(wd);
		if (sorted)
			for (int k = 1; k < ENTRIES; k++) begin
				wd.entry_rank = wsrt_pkg::RANK_W'(k);
				wd.entry_speed = records[k].speed;
				wd.entry_hour = records[k].hour;
				wd.entry_minute = records[k].minute;
				wd.entry_second = records[k].second;
				wd.entry_run = records[k].run;
				wd.last = (k == ENTRIES - 1);
				expected_words.push_back(wd);
			end
	endfunction

	task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		wsrt_pkg::result_t e;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %p", $time, result);
				errors++;
			end else begin
				e = expected_words.pop_front();
				check_field("window_average", e.window_average, result.window_average);
				check_field("run_maximum", e.run_maximum, result.run_maximum);
				check_field("display_maximum", e.display_maximum, result.display_maximum);
				check_field("entry_rank", 24'(e.entry_rank), 24'(result.entry_rank));
				check_field("entry_speed", e.entry_speed, result.entry_speed);
				check_field("entry_hour", 24'(e.entry_hour), 24'(result.entry_hour));
				check_field("entry_minute", 24'(e.entry_minute), 24'(result.entry_minute));
				check_field("entry_second", 24'(e.entry_second), 24'(result.entry_second));
				check_field("entry_run", 24'(e.entry_run), 24'(result.entry_run));
				check_field("last", 24'(e.last), 24'(result.last));
			end
		end
	end

	task automatic send_sample(logic [15:0] spd, logic [15:0] run);
		wsrt_pkg::item_t it;
		while (idling && $urandom_range(99) < 30) begin
			push <= 0;
			@(posedge clk);
		end
		ss = ss + 6'($urandom_range(1));
		if (ss > 59) begin
			ss = 0;
			mm = (mm == 59) ? 6'd0 : mm + 6'd1;
			if (mm == 0)
				hh = (hh == 23) ? 5'd0 : hh + 5'd1;
		end
		it = '{spd, run, hh, mm, ss};
		push <= 1;
		item <= it;
		do @(posedge clk); while (full);
		predict_words(it);
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [wsrt_pkg::CFG_IDX_W-1:0] idx,
		logic [wsrt_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == wsrt_pkg::CFG_WINDOW)
			win_secs = val[wsrt_pkg::WIN_W-1:0];
		else if (idx == wsrt_pkg::CFG_RATE)
			rate = val[wsrt_pkg::RATE_W-1:0];
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic setup(logic [wsrt_pkg::CFG_DATA_W-1:0] w, logic [wsrt_pkg::CFG_DATA_W-1:0] r);
		write_reg(wsrt_pkg::CFG_WINDOW, w);
		write_reg(wsrt_pkg::CFG_RATE, r);
	endtask

	// random runs: steady speed per run, occasional noise words
	task automatic run_burst(int n);
		logic [15:0] run, base;
		int len;
		run = 16'($urandom);
		while (n > 0) begin
			if ($urandom_range(9) == 0) begin
				send_sample(16'($urandom), 16'($urandom));
				n--;
			end else begin
				run = ($urandom_range(3) == 0) ? run + 16'd1 : 16'($urandom);
				base = 16'($urandom);
				len = $urandom_range(2, 14);
				for (int i = 0; i < len && n > 0; i++, n--)
					send_sample(base ^ 16'($urandom_range(255)), run);
			end
		end
	endtask

	task automatic test_directed();
		send_sample(16'hFFFF, 16'd5);
		send_sample(16'hFFFF, 16'd5);
		send_sample(16'd0, 16'd5);
		send_sample(16'd0, 16'd6);
		send_sample(16'h8000, 16'hFFFF);
		send_sample(16'h7FFF, 16'hFFFF);
		hh = 23; mm = 59; ss = 58;
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'd1, 16'd0);
		for (int i = 0; i < 12; i++)
			send_sample(16'(i * 5000), 16'(i / 2 + 100));
		drain();
	endtask

	task automatic test_zero_registers();
		setup(12'd0, 12'd0);
		for (int i = 0; i < 12; i++)
			send_sample(16'($urandom), 16'(i / 3));
		drain();
	endtask

	task automatic test_high_rate();
		setup(12'd1, 12'hFFF);
		run_burst(20);
		drain();
	endtask

	task automatic test_second_mode();
		setup(12'd3600, 12'd25);
		run_burst(30);
		drain();
		setup(12'hFFF, 12'd1);
		run_burst(15);
		drain();
	endtask

	task automatic test_ring_edge();
		setup(12'd204, 12'd10);
		run_burst(20);
		drain();
		setup(12'd205, 12'd10);
		run_burst(20);
		drain();
	endtask

	task automatic test_random();
		idling = 0;
		setup(12'd10, 12'd10);
		run_burst(30);
		idling = 1;
		drain();
		for (int c = 0; c < 3; c++) begin
			setup(12'($urandom_range(1, 300)), 12'($urandom_range(1, 25)));
			run_burst(20);
			drain();
		end
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		pop = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = wsrt_pkg::CFG_WINDOW;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		idling = 1;
		hh = 0; mm = 0; ss = 0;
		win_secs = wsrt_pkg::WINDOW_RESET;
		rate = wsrt_pkg::RATE_RESET;
		foreach (speed_ring[i]) speed_ring[i] = 0;
		foreach (mean_ring[i]) mean_ring[i] = 0;
		foreach (records[i]) records[i] = '0;
		speed_idx = 0;
		mean_idx = 32'hFFFFFFFF;
		sec_acc = 0;
		win_sum = 0;
		run_max = 0;
		prev_run = 0;
		avg = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_zero_registers();
		test_high_rate();
		test_second_mode();
		test_ring_edge();
		test_random();
		if (errors == 0)
			$display("windowed_speed_record_tracker_tb: PASS");
		else
			$display("windowed_speed_record_tracker_tb: FAIL");
		$finish;
	end
endmodule
